// File: rtl/owce_pkg.sv
// Package for the 1-Wire chain enumerator: bus action codes, completion
// kinds, command bytes, command sequence table and the Dallas CRC8 step.
// No dependencies.
`default_nettype none

package owce_pkg;

    // Bus action codes (result field action)
    localparam logic [2:0] ACT_RESET = 3'd0;
    localparam logic [2:0] ACT_WRITE = 3'd1;
    localparam logic [2:0] ACT_READ  = 3'd2;
    localparam logic [2:0] ACT_DONE  = 3'd3;
    localparam logic [2:0] ACT_NONE  = 3'd4;

    // Completion kinds (input field kind)
    localparam logic [1:0] KIND_START = 2'd0;
    localparam logic [1:0] KIND_RESET = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;
    localparam logic [1:0] KIND_WRITE = 2'd3;

    // Command groups
    localparam logic [1:0] GRP_OFF  = 2'd0;
    localparam logic [1:0] GRP_ON   = 2'd1;
    localparam logic [1:0] GRP_DEV  = 2'd2;
    localparam logic [1:0] GRP_DONE = 2'd3;

    // Command bytes
    localparam logic [7:0] CMD_BROADCAST = 8'hCC;
    localparam logic [7:0] CMD_READ_ROM  = 8'hEC;
    localparam logic [7:0] CMD_CHAIN     = 8'h99;
    localparam logic [7:0] CMD_OFF       = 8'h3C;
    localparam logic [7:0] CMD_OFF_INV   = 8'hC3;
    localparam logic [7:0] CMD_ON        = 8'h5A;
    localparam logic [7:0] CMD_ON_INV    = 8'hA5;
    localparam logic [7:0] CMD_DONE      = 8'h96;
    localparam logic [7:0] CMD_DONE_INV  = 8'h69;
    localparam logic [7:0] FAMILY_EMPTY  = 8'h00;
    localparam logic [7:0] FAMILY_FLOAT  = 8'hFF;
    localparam logic [7:0] CRC_POLY_REV  = 8'h8C;

    localparam int MAX_DEVICES_DEF = 32;

    // Byte sent at a given step of a command group
    function automatic logic [7:0] cmd_byte(input logic [1:0] grp, input logic [1:0] step);
        logic [7:0] b;
        b = CMD_CHAIN;
        case (grp)
            GRP_OFF: begin
                case (step)
                    2'd0:    b = CMD_BROADCAST;
                    2'd1:    b = CMD_CHAIN;
                    2'd2:    b = CMD_OFF;
                    default: b = CMD_OFF_INV;
                endcase
            end
            GRP_ON: begin
                case (step)
                    2'd0:    b = CMD_BROADCAST;
                    2'd1:    b = CMD_CHAIN;
                    2'd2:    b = CMD_ON;
                    default: b = CMD_ON_INV;
                endcase
            end
            GRP_DEV: begin
                case (step)
                    2'd0:    b = CMD_CHAIN;
                    2'd1:    b = CMD_ON;
                    2'd2:    b = CMD_ON_INV;
                    default: b = CMD_READ_ROM;
                endcase
            end
            default: begin
                case (step)
                    2'd0:    b = CMD_BROADCAST;
                    2'd1:    b = CMD_CHAIN;
                    2'd2:    b = CMD_DONE;
                    default: b = CMD_DONE_INV;
                endcase
            end
        endcase
        return b;
    endfunction

    // Dallas CRC8, LSB first, one byte
    function automatic logic [7:0] crc8_update(input logic [7:0] crc_in, input logic [7:0] data);
        logic [7:0] c;
        logic [7:0] d;
        logic       mix;
        c = crc_in;
        d = data;
        for (int i = 0; i < 8; i++) begin
            mix = c[0] ^ d[0];
            c   = {1'b0, c[7:1]};
            if (mix) begin
                c = c ^ CRC_POLY_REV;
            end
            d = {1'b0, d[7:1]};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// File: rtl/one_wire_chain_enumerator.sv
// One-Wire chain enumerator top level: sequencer state, CRC check and
// registered result stage. Depends on owce_pkg.
`default_nettype none

// Sequencer that sits in front of a 1-Wire bus master and walks a chain of
// chain-mode devices. Send a start item (kind 0) to begin; every result names
// the next bus operation (reset, write a byte, read a byte, finished, or no
// action). Feed back each completion: kind 1 with the presence flag after a
// reset, kind 2 with the byte after a read, kind 3 after a write. The flow is
// chain OFF for all devices, chain ON for all, then per device: reset, chain
// ON, read-ROM and eight byte reads, with a CRC8 check on byte 7, up to
// MAX_DEVICES devices; then chain DONE. A valid ROM comes out with the reset
// that follows its last byte, flagged by rom_valid, with its chain slot.
// Items that the sequencer is not waiting for leave the state alone and give
// action "no action". Every accepted item yields exactly one result item, held
// in the registered result stage; a new item is taken every cycle as long as the
// result register is empty or being drained, so throughput is one item per
// clock, bounded only by the single state/result register stage.
module one_wire_chain_enumerator
    import owce_pkg::*;
#(
    parameter int MAX_DEVICES = MAX_DEVICES_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // input channel
    input  wire         i_in_valid,
    output logic        o_in_stall,
    input  wire  [1:0]  i_kind,
    input  wire         i_presence,
    input  wire  [7:0]  i_read_byte,
    // result channel
    output logic        o_out_valid,
    input  wire         i_out_stall,
    output logic [2:0]  o_action,
    output logic [7:0]  o_write_value,
    output logic        o_rom_valid,
    output logic [63:0] o_rom_code,
    output logic [4:0]  o_rom_slot,
    output logic [5:0]  o_found_count,
    output logic        o_success
);

    typedef enum logic [3:0] {
        PH_IDLE     = 4'd0,
        PH_RST_OFF  = 4'd1,
        PH_W_OFF    = 4'd2,
        PH_RST_ON   = 4'd3,
        PH_W_ON     = 4'd4,
        PH_RST_DEV  = 4'd5,
        PH_W_DEV    = 4'd6,
        PH_READ     = 4'd7,
        PH_RST_DONE = 4'd8,
        PH_W_DONE   = 4'd9
    } t_phase;

    localparam logic [5:0] DEV_LIMIT = 6'(MAX_DEVICES);

    // sequencer state
    t_phase      r_phase,      n_phase;
    logic [1:0]  r_write_step, n_write_step;
    logic [2:0]  r_byte_step,  n_byte_step;
    logic [7:0]  r_crc,        n_crc;
    logic [63:0] r_rom,        n_rom;
    logic [5:0]  r_dev_count,  n_dev_count;

    // result register
    logic        r_out_valid;
    logic [2:0]  r_action,     n_action;
    logic [7:0]  r_write_val,  n_write_val;
    logic        r_rom_valid,  n_rom_valid;
    logic [63:0] r_rom_code,   n_rom_code;
    logic [4:0]  r_rom_slot,   n_rom_slot;
    logic        r_success,    n_success;

    logic        in_acc;
    logic [1:0]  grp;
    logic [63:0] rom_merged;

    // Stall only when a result is parked and downstream holds it.
    assign o_in_stall = r_out_valid & i_out_stall;
    assign in_acc     = i_in_valid & ~o_in_stall;

    // Command group of the current write phase
    always_comb begin
        case (r_phase)
            PH_W_OFF: grp = GRP_OFF;
            PH_W_ON:  grp = GRP_ON;
            PH_W_DEV: grp = GRP_DEV;
            default:  grp = GRP_DONE;
        endcase
    end

    // ROM with the incoming byte merged at the current byte position
    always_comb begin
        for (int k = 0; k < 8; k++) begin
            rom_merged[8*k +: 8] = r_rom[8*k +: 8] |
                                   ((r_byte_step == 3'(k)) ? i_read_byte : 8'h00);
        end
    end

    // Next state and result for the item at the input
    always_comb begin
        n_phase      = r_phase;
        n_write_step = r_write_step;
        n_byte_step  = r_byte_step;
        n_crc        = r_crc;
        n_rom        = r_rom;
        n_dev_count  = r_dev_count;
        n_action     = ACT_NONE;
        n_write_val  = 8'h00;
        n_rom_valid  = 1'b0;
        n_rom_code   = 64'h0;
        n_rom_slot   = 5'd0;
        n_success    = 1'b0;

        case (r_phase)
            PH_IDLE: begin
                if (i_kind == KIND_START) begin
                    n_dev_count = 6'd0;
                    n_phase     = PH_RST_OFF;
                    n_action    = ACT_RESET;
                end
            end
            PH_RST_OFF, PH_RST_ON: begin
                if (i_kind == KIND_RESET) begin
                    if (!i_presence) begin
                        n_phase  = PH_IDLE;
                        n_action = ACT_DONE;
                    end else begin
                        n_phase      = (r_phase == PH_RST_OFF) ? PH_W_OFF : PH_W_ON;
                        n_write_step = 2'd0;
                        n_action     = ACT_WRITE;
                        n_write_val  = cmd_byte((r_phase == PH_RST_OFF) ? GRP_OFF : GRP_ON,
                                                2'd0);
                    end
                end
            end
            PH_RST_DEV: begin
                if (i_kind == KIND_RESET) begin
                    if (!i_presence) begin
                        n_phase  = PH_RST_DONE;
                        n_action = ACT_RESET;
                    end else begin
                        n_phase      = PH_W_DEV;
                        n_write_step = 2'd0;
                        n_action     = ACT_WRITE;
                        n_write_val  = cmd_byte(GRP_DEV, 2'd0);
                    end
                end
            end
            PH_RST_DONE: begin
                if (i_kind == KIND_RESET) begin
                    if (!i_presence) begin
                        n_phase   = PH_IDLE;
                        n_action  = ACT_DONE;
                        n_success = (r_dev_count != 6'd0);
                    end else begin
                        n_phase      = PH_W_DONE;
                        n_write_step = 2'd0;
                        n_action     = ACT_WRITE;
                        n_write_val  = cmd_byte(GRP_DONE, 2'd0);
                    end
                end
            end
            PH_W_OFF, PH_W_ON, PH_W_DEV, PH_W_DONE: begin
                if (i_kind == KIND_WRITE) begin
                    if (r_write_step != 2'd3) begin
                        n_write_step = r_write_step + 2'd1;
                        n_action     = ACT_WRITE;
                        n_write_val  = cmd_byte(grp, r_write_step + 2'd1);
                    end else begin
                        n_write_step = 2'd0;
                        case (grp)
                            GRP_OFF: begin
                                n_phase  = PH_RST_ON;
                                n_action = ACT_RESET;
                            end
                            GRP_ON: begin
                                n_phase  = (r_dev_count < DEV_LIMIT) ? PH_RST_DEV
                                                                     : PH_RST_DONE;
                                n_action = ACT_RESET;
                            end
                            GRP_DEV: begin
                                n_phase     = PH_READ;
                                n_byte_step = 3'd0;
                                n_crc       = 8'h00;
                                n_rom       = 64'h0;
                                n_action    = ACT_READ;
                            end
                            default: begin
                                n_phase   = PH_IDLE;
                                n_action  = ACT_DONE;
                                n_success = (r_dev_count != 6'd0);
                            end
                        endcase
                    end
                end
            end
            PH_READ: begin
                if (i_kind == KIND_READ) begin
                    n_rom = rom_merged;
                    if (r_byte_step != 3'd7) begin
                        n_crc       = crc8_update(r_crc, i_read_byte);
                        n_byte_step = r_byte_step + 3'd1;
                        n_action    = ACT_READ;
                    end else begin
                        n_byte_step = 3'd0;
                        n_action    = ACT_RESET;
                        // end of chain: empty or floating family, or bad CRC
                        if ((rom_merged[7:0] == FAMILY_EMPTY) ||
                            (rom_merged[7:0] == FAMILY_FLOAT) ||
                            (r_crc != i_read_byte)) begin
                            n_phase = PH_RST_DONE;
                        end else begin
                            n_dev_count = r_dev_count + 6'd1;
                            n_phase     = (n_dev_count < DEV_LIMIT) ? PH_RST_DEV
                                                                    : PH_RST_DONE;
                            n_rom_valid = 1'b1;
                            n_rom_code  = rom_merged;
                            n_rom_slot  = r_dev_count[4:0];
                        end
                    end
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_write_step <= 2'd0;
            r_byte_step  <= 3'd0;
            r_crc        <= 8'h00;
            r_rom        <= 64'h0;
            r_dev_count  <= 6'd0;
            r_out_valid  <= 1'b0;
        end else begin
            if (in_acc) begin
                r_phase      <= n_phase;
                r_write_step <= n_write_step;
                r_byte_step  <= n_byte_step;
                r_crc        <= n_crc;
                r_rom        <= n_rom;
                r_dev_count  <= n_dev_count;
                r_out_valid  <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid  <= 1'b0;
            end
        end
    end

    // result payload, loaded with each accepted item
    logic [5:0] r_found;
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_action    <= n_action;
            r_write_val <= n_write_val;
            r_rom_valid <= n_rom_valid;
            r_rom_code  <= n_rom_code;
            r_rom_slot  <= n_rom_slot;
            r_found     <= n_dev_count;
            r_success   <= n_success;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_action      = r_action;
    assign o_write_value = r_write_val;
    assign o_rom_valid   = r_rom_valid;
    assign o_rom_code    = r_rom_code;
    assign o_rom_slot    = r_rom_slot;
    assign o_found_count = r_found;
    assign o_success     = r_success;

    // A reported ROM always travels with the reset that follows it.
    a_rom_with_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_rom_valid) |-> (o_action == ACT_RESET))
        else $error("ROM reported without a bus reset");

    // Success only on finish, and only with at least one ROM found.
    a_success_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_success) |-> (o_action == ACT_DONE && o_found_count != 6'd0))
        else $error("success flagged outside a finish or with no ROM found");

    // Device count never passes the chain limit.
    a_count_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dev_count <= DEV_LIMIT)
        else $error("device count beyond limit");

    // A start taken in idle restarts the count and asks for a bus reset.
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && r_phase == PH_IDLE && i_kind == KIND_START) |=>
        (o_out_valid && o_found_count == 6'd0 && o_action == ACT_RESET))
        else $error("start did not restart discovery");

endmodule

`default_nettype wire
